### rtl/core/assert_macros.svh
// Assertion macros shared by the transform engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/mvt_pkg.sv
// Types and constants for the 4x4 matrix-vector transform engine.
package mvt_pkg;

    localparam int WORD_W = 32;            // Q16.16 word
    localparam int DIM    = 4;             // rows, columns, components
    localparam int IDX_W  = 4;             // entry index, row*4+col
    localparam int COL_W  = 2;             // column part of the index
    localparam int ROW_W  = IDX_W - COL_W; // row part of the index
    localparam int PROD_W = 2 * WORD_W;    // exact product
    localparam int ACC_W  = PROD_W + 2;    // exact sum of four products

    typedef enum logic
    {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } op_t;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed
    {
        op_t              operation;
        logic [IDX_W-1:0] entry_index;
        word_t            entry_value;
        word_t            in_x;
        word_t            in_y;
        word_t            in_z;
        word_t            in_w;
    } in_item_t;

    typedef struct packed
    {
        word_t out_x;
        word_t out_y;
        word_t out_z;
        word_t out_w;
        logic  clipped;
    } out_item_t;

    // What one cell hands to the next: the item itself, the running row
    // sums and this cell's products, one per row.
    typedef struct packed
    {
        logic                        valid;
        op_t                         operation;
        logic [IDX_W-1:0]            entry_index;
        word_t                       entry_value;
        logic [DIM-1:0][WORD_W-1:0]  vec;
        logic [DIM-1:0][ACC_W-1:0]   sum;
        logic [DIM-1:0][PROD_W-1:0]  prod;
    } cell_link_t;

endpackage

### rtl/core/mvt_cell.sv
// One column cell: holds a matrix column, forms its products, adds the upstream ones.
`include "assert_macros.svh"

module mvt_cell #(
    parameter int COL       = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  mvt_pkg::cell_link_t link_in,
    output mvt_pkg::cell_link_t link_out
);

    localparam int W      = mvt_pkg::WORD_W;
    localparam int DIM    = mvt_pkg::DIM;
    localparam int IDX_W  = mvt_pkg::IDX_W;
    localparam int COL_W  = mvt_pkg::COL_W;
    localparam int ROW_W  = mvt_pkg::ROW_W;
    localparam int PROD_W = mvt_pkg::PROD_W;
    localparam int ACC_W  = mvt_pkg::ACC_W;
    localparam logic [W-1:0] UNIT = W'(1) << FRAC_BITS;

    logic [DIM-1:0][W-1:0] col_reg;
    logic [DIM-1:0][W-1:0] col_next;
    logic                  valid_reg;
    mvt_pkg::cell_link_t   data_reg;
    mvt_pkg::cell_link_t   data_next;
    logic                  load_hit;
    logic [ROW_W-1:0]      hit_row;

    // Loads travel down the chain, so an entry changes only after every
    // earlier transform has passed this cell.
    always_comb
    begin
        load_hit = link_in.valid
                   && (link_in.operation == mvt_pkg::OP_LOAD)
                   && (link_in.entry_index[COL_W-1:0] == COL_W'(COL));
        hit_row  = link_in.entry_index[IDX_W-1:COL_W];
        col_next = col_reg;
        if (load_hit)
        begin
            col_next[hit_row] = link_in.entry_value;
        end
    end

    always_comb
    begin
        logic signed [W-1:0]      m;
        logic signed [W-1:0]      v;
        logic signed [PROD_W-1:0] p;
        logic        [PROD_W-1:0] p_in;
        data_next = link_in;
        for (int r = 0; r < DIM; r++)
        begin
            m    = $signed(col_reg[r]);
            v    = $signed(link_in.vec[COL]);
            p    = m * v;
            p_in = link_in.prod[r];
            data_next.prod[r] = p;
            data_next.sum[r]  = link_in.sum[r]
                                + {{(ACC_W-PROD_W){p_in[PROD_W-1]}}, p_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int r = 0; r < DIM; r++)
            begin
                col_reg[r] <= (r == COL) ? UNIT : '0;
            end
        end
        else if (adv)
        begin
            valid_reg <= link_in.valid;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        link_out       = data_reg;
        link_out.valid = valid_reg;
    end

    `ASSERT_CLK(a_load_lands, adv && load_hit |=> col_reg[$past(hit_row)] == $past(link_in.entry_value), "load did not reach its column entry")
    `ASSERT_CLK(a_hold_on_stall, !adv |=> col_reg == $past(col_reg), "column changed while stalled")
    `ASSERT_CLK(a_bubble_kept, !adv |=> valid_reg == $past(valid_reg), "cell valid changed while stalled")

endmodule

### rtl/core/mvt_tail.sv
// Final add, floor shift, saturation and the output register.
`include "assert_macros.svh"

module mvt_tail #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mvt_pkg::cell_link_t link_in,
    input  logic               result_ready,
    output logic               adv,
    output logic               result_valid,
    output mvt_pkg::out_item_t result
);

    localparam int W      = mvt_pkg::WORD_W;
    localparam int DIM    = mvt_pkg::DIM;
    localparam int PROD_W = mvt_pkg::PROD_W;
    localparam int ACC_W  = mvt_pkg::ACC_W;
    localparam logic [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_WORD = {1'b1, {(W-1){1'b0}}};

    logic                      a_valid_reg;
    logic [DIM-1:0][ACC_W-1:0] total_reg;
    logic [DIM-1:0][ACC_W-1:0] total_next;
    logic [DIM-1:0][W-1:0]     word_next;
    logic                      clip_next;
    logic                      result_valid_reg;
    mvt_pkg::out_item_t        result_reg;
    mvt_pkg::out_item_t        result_next;

    // Whole chain moves when the output register is free or being taken.
    assign adv = !result_valid_reg || result_ready;

    always_comb
    begin
        logic [PROD_W-1:0] p;
        for (int r = 0; r < DIM; r++)
        begin
            p             = link_in.prod[r];
            total_next[r] = link_in.sum[r] + {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
        end
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] shifted;
        logic                    fits;
        clip_next = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            shifted = $signed(total_reg[r]) >>> FRAC_BITS;
            fits    = (&shifted[ACC_W-1:W-1]) || !(|shifted[ACC_W-1:W-1]);
            if (fits)
            begin
                word_next[r] = shifted[W-1:0];
            end
            else
            begin
                word_next[r] = shifted[ACC_W-1] ? MIN_WORD : MAX_WORD;
                clip_next    = 1'b1;
            end
        end
        result_next.out_x   = word_next[0];
        result_next.out_y   = word_next[1];
        result_next.out_z   = word_next[2];
        result_next.out_w   = word_next[3];
        result_next.clipped = clip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg      <= link_in.valid
                                && (link_in.operation == mvt_pkg::OP_TRANSFORM);
            result_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            total_reg  <= total_next;
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_CLK(a_clip_pinned, result_valid && result.clipped |-> (result.out_x == MAX_WORD || result.out_x == MIN_WORD || result.out_y == MAX_WORD || result.out_y == MIN_WORD || result.out_z == MAX_WORD || result.out_z == MIN_WORD || result.out_w == MAX_WORD || result.out_w == MIN_WORD), "clip flag without a saturated component")
    `ASSERT_CLK(a_result_source, $rose(result_valid) |-> $past(a_valid_reg), "result appeared without a transform behind it")
    `ASSERT_CLK(a_load_no_result, adv && link_in.valid && link_in.operation == mvt_pkg::OP_LOAD |=> !a_valid_reg, "load entered the result path")
    `ASSERT_NEVER(a_valid_known, $isunknown(result_valid), "result valid unknown out of reset")

endmodule

### rtl/core/matrix_vector_transform_4x4.sv
// Top level: 4x4 Q16.16 matrix times vector engine built as a chain of column cells.
// Path: a transform is registered by cell 0 at its transfer, then by cells 1-3, the final add stage
//   and the output register, where its result is shown.
// Throughput: one item per cycle, loads and transforms mixed freely; a held output stalls
//   the whole chain, as every stage moves on one shared advance.
// Reset: asynchronous, active low; the matrix returns to identity and the chain empties.
module matrix_vector_transform_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mvt_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output mvt_pkg::out_item_t result
);

    localparam int DIM = mvt_pkg::DIM;

    // links[k] feeds cell k; links[DIM] feeds the tail.
    mvt_pkg::cell_link_t links [DIM+1];
    logic                adv;

    // A transfer happens whenever the chain advances, so ready is simply
    // the advance: it drops only while a finished result is held unread.
    assign item_ready = adv;

    // Entry into the chain. Sums and products start at zero; cell 0 adds
    // nothing of its own upstream and just forms column 0 products.
    always_comb
    begin
        links[0]             = '0;
        links[0].valid       = item_valid;
        links[0].operation   = item.operation;
        links[0].entry_index = item.entry_index;
        links[0].entry_value = item.entry_value;
        links[0].vec[0]      = item.in_x;
        links[0].vec[1]      = item.in_y;
        links[0].vec[2]      = item.in_z;
        links[0].vec[3]      = item.in_w;
    end

    // Column cells. Each one owns a matrix column; a load is written when
    // it reaches its column's cell, which keeps every transform in flight
    // on the matrix it saw at its transfer.
    for (genvar k = 0; k < DIM; k++)
    begin : g_cell
        mvt_cell #(
            .COL       (k),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .link_in  (links[k]),
            .link_out (links[k+1])
        );
    end

    // Last product joins the sums, then floor shift and saturation into
    // the output register. Loads are dropped here.
    mvt_tail #(
        .FRAC_BITS (FRAC_BITS)
    ) u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .link_in      (links[DIM]),
        .result_ready (result_ready),
        .adv          (adv),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
